FILE: rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ppt_pkg.sv
`timescale 1ns / 1ps

package ppt_pkg;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_UNMAP     = 2'd1,
        OP_UNMAP_ALL = 2'd2,
        OP_TRANSLATE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FIN1,
        ST_FIN2,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic busy;
        logic issue;
        logic fin1;
        logic fin2;
        logic resp;
    } ctrl_t;

    typedef struct packed {
        logic [31:0] vbase;
        logic [31:0] page_len;
        logic [31:0] phys_even;
        logic [31:0] phys_odd;
    } entry_t;

    localparam logic [31:0] SIZE_FLOOR_MASK    = 32'h0000_1FFF;
    localparam logic [31:0] WINDOW_LOW         = 32'h8000_0000;
    localparam logic [31:0] WINDOW_HIGH        = 32'hC000_0000;
    localparam logic [31:0] WINDOW_OFFSET_MASK = 32'h1FFF_FFFF;

endpackage

FILE: rtl/ppt_addsub.sv
`timescale 1ns / 1ps

module ppt_addsub
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        sub,
    output logic [31:0] sum
);

    assign sum = sub ? (a - b) : (a + b);

endmodule

FILE: rtl/ppt_entry_mem.sv
`timescale 1ns / 1ps

module ppt_entry_mem
#(
    parameter int ENTRY_COUNT = 32,
    parameter int IDX_W       = 5
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  ppt_pkg::entry_t      wdata,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr,
    output ppt_pkg::entry_t      rdata
);

    ppt_pkg::entry_t mem [ENTRY_COUNT];
    ppt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ppt_seq.sv
`timescale 1ns / 1ps

module ppt_seq
#(
    parameter int ENTRY_COUNT = 32,
    parameter int IDX_W       = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 walk_op,
    input  logic                 last_done,
    output ppt_pkg::ctrl_t       ctrl,
    output logic [IDX_W-1:0]     rd_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

    ppt_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppt_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctrl       = '0;
        case (state_reg)
            ppt_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    state_next = walk_op ? ppt_pkg::ST_WALK : ppt_pkg::ST_RESP;
                end
            end
            ppt_pkg::ST_WALK:
            begin
                ctrl.busy  = 1'b1;
                ctrl.issue = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ppt_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ppt_pkg::ST_DRAIN:
            begin
                ctrl.busy = 1'b1;
                if (last_done)
                begin
                    state_next = ppt_pkg::ST_FIN1;
                end
            end
            ppt_pkg::ST_FIN1:
            begin
                ctrl.busy  = 1'b1;
                ctrl.fin1  = 1'b1;
                state_next = ppt_pkg::ST_FIN2;
            end
            ppt_pkg::ST_FIN2:
            begin
                ctrl.busy  = 1'b1;
                ctrl.fin2  = 1'b1;
                state_next = ppt_pkg::ST_RESP;
            end
            ppt_pkg::ST_RESP:
            begin
                ctrl.busy  = 1'b1;
                ctrl.resp  = 1'b1;
                state_next = ppt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ppt_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_idx = idx_reg;

endmodule

FILE: rtl/paired_page_tlb_translator.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Paired-page translation table. An operation is taken when start is high and busy is
// low; every operation gives exactly one result, shown for one cycle with done high,
// and the receiver cannot stall it, so it must sample the result in that cycle. Map,
// unmap-all and translates that hit the direct window show done in the cycle right
// after accept; unmap by address and table translates walk the table one entry per
// cycle through the single read port of the entry memory and one shared adder, then
// drain the read pipeline and finish the result before done. busy stays high until
// the done cycle has passed.
module paired_page_tlb_translator
#(
    parameter int ENTRY_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [5:0]  entry_index,
    input  logic [31:0] pair_mask,
    input  logic [31:0] address,
    input  logic [31:0] phys_even,
    input  logic [31:0] phys_odd,
    output logic        done,
    output logic [31:0] physical_address,
    output logic        tlb_hit,
    output logic        direct_mapped
);

    localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

    ppt_pkg::ctrl_t   ctrl;
    logic [IDX_W-1:0] rd_idx;
    logic             accept;
    ppt_pkg::op_t     in_op;
    logic             in_direct;
    logic             walk_op;

    ppt_pkg::op_t     op_reg;
    logic [31:0]      va_reg;

    logic [31:0]      alu_a, alu_b, alu_sum;
    logic             alu_sub;

    ppt_pkg::entry_t  wr_entry, rd_entry;
    logic             map_we;

    logic             s1_vld_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_vld_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [31:0]      s2_vbase_reg;
    logic [31:0]      s2_size_reg;
    logic [31:0]      s2_sum_reg;
    logic [31:0]      s2_pe_reg;
    logic [31:0]      s2_po_reg;
    logic             last_done;

    logic [ENTRY_COUNT-1:0] valid_reg;
    logic             s2_entry_valid;
    logic             unmap_hit;

    logic             found_reg;
    logic [31:0]      m_off_reg, m_sub_reg, m_base_reg;
    logic [31:0]      adj_reg;

    logic [31:0]      pa_reg;
    logic             hit_reg;
    logic             direct_reg;

    assign accept    = start && !ctrl.busy;
    assign in_op     = ppt_pkg::op_t'(operation);
    assign in_direct = (address >= ppt_pkg::WINDOW_LOW) && (address < ppt_pkg::WINDOW_HIGH);
    assign walk_op   = (in_op == ppt_pkg::OP_UNMAP) ||
                       ((in_op == ppt_pkg::OP_TRANSLATE) && !in_direct);

    ppt_seq #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDX_W       (IDX_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .walk_op   (walk_op),
        .last_done (last_done),
        .ctrl      (ctrl),
        .rd_idx    (rd_idx)
    );

    // shared adder operand select
    always_comb
    begin
        alu_a   = pair_mask | ppt_pkg::SIZE_FLOOR_MASK;
        alu_b   = 32'd1;
        alu_sub = 1'b0;
        if (s1_vld_reg)
        begin
            if (op_reg == ppt_pkg::OP_TRANSLATE)
            begin
                alu_a   = va_reg;
                alu_b   = rd_entry.vbase;
                alu_sub = 1'b1;
            end
            else
            begin
                alu_a = rd_entry.vbase;
                alu_b = {rd_entry.page_len[30:0], 1'b0};
            end
        end
        else if (ctrl.fin1)
        begin
            alu_a   = m_off_reg;
            alu_b   = m_sub_reg;
            alu_sub = 1'b1;
        end
        else if (ctrl.fin2)
        begin
            alu_a = m_base_reg;
            alu_b = adj_reg;
        end
    end

    ppt_addsub u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign map_we = accept && (in_op == ppt_pkg::OP_MAP) &&
                    ({1'b0, entry_index} < 7'(ENTRY_COUNT));

    always_comb
    begin
        wr_entry.vbase     = address;
        wr_entry.page_len  = {1'b0, alu_sum[31:1]};
        wr_entry.phys_even = phys_even;
        wr_entry.phys_odd  = phys_odd;
    end

    ppt_entry_mem #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDX_W       (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (map_we),
        .waddr (entry_index[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ctrl.issue),
        .raddr (rd_idx),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_op;
            va_reg <= address;
        end
    end

    // walk pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s1_idx_reg <= '0;
            s2_vld_reg <= 1'b0;
            s2_idx_reg <= '0;
        end
        else
        begin
            s1_vld_reg <= ctrl.issue;
            s1_idx_reg <= rd_idx;
            s2_vld_reg <= s1_vld_reg;
            s2_idx_reg <= s1_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            s2_vbase_reg <= rd_entry.vbase;
            s2_size_reg  <= rd_entry.page_len;
            s2_sum_reg   <= alu_sum;
            s2_pe_reg    <= rd_entry.phys_even;
            s2_po_reg    <= rd_entry.phys_odd;
        end
    end

    assign last_done      = s2_vld_reg && (s2_idx_reg == LAST_IDX);
    assign s2_entry_valid = valid_reg[s2_idx_reg];
    assign unmap_hit      = s2_vld_reg && (op_reg == ppt_pkg::OP_UNMAP) && s2_entry_valid &&
                            (va_reg >= s2_vbase_reg) && (va_reg < s2_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (accept && (in_op == ppt_pkg::OP_UNMAP_ALL))
        begin
            valid_reg <= '0;
        end
        else if (map_we)
        begin
            valid_reg[entry_index[IDX_W-1:0]] <= (alu_sum[31:1] != 31'd0);
        end
        else if (unmap_hit)
        begin
            valid_reg[s2_idx_reg] <= 1'b0;
        end
    end

    // first matching entry wins
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg <= 1'b0;
        end
        else if (s2_vld_reg && (op_reg == ppt_pkg::OP_TRANSLATE) && s2_entry_valid &&
                 !found_reg)
        begin
            if (s2_sum_reg < s2_size_reg)
            begin
                found_reg  <= 1'b1;
                m_off_reg  <= s2_sum_reg;
                m_sub_reg  <= '0;
                m_base_reg <= s2_pe_reg;
            end
            else if (s2_sum_reg < {s2_size_reg[30:0], 1'b0})
            begin
                found_reg  <= 1'b1;
                m_off_reg  <= s2_sum_reg;
                m_sub_reg  <= s2_size_reg;
                m_base_reg <= s2_po_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin1)
        begin
            adj_reg <= alu_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg    <= 1'b0;
            direct_reg <= (in_op == ppt_pkg::OP_TRANSLATE) && in_direct;
            if ((in_op == ppt_pkg::OP_TRANSLATE) && in_direct)
            begin
                pa_reg <= address & ppt_pkg::WINDOW_OFFSET_MASK;
            end
            else
            begin
                pa_reg <= '0;
            end
        end
        else if (ctrl.fin2)
        begin
            direct_reg <= 1'b0;
            if (op_reg == ppt_pkg::OP_TRANSLATE)
            begin
                hit_reg <= found_reg;
                pa_reg  <= (found_reg && (alu_sum != 32'd0)) ? alu_sum : va_reg;
            end
            else
            begin
                hit_reg <= 1'b0;
                pa_reg  <= '0;
            end
        end
    end

    assign busy             = ctrl.busy;
    assign done             = ctrl.resp;
    assign physical_address = pa_reg;
    assign tlb_hit          = hit_reg;
    assign direct_mapped    = direct_reg;

    `PPT_ASSERT_NOW(a_done_one_beat, done, !accept)
    `PPT_ASSERT_NEXT(a_unmap_all_clears, accept && (in_op == ppt_pkg::OP_UNMAP_ALL), valid_reg == '0)
    `PPT_ASSERT_NOW(a_hit_not_direct, done, !(tlb_hit && direct_mapped))
    `PPT_ASSERT_NOW(a_walk_only_busy, s1_vld_reg || s2_vld_reg, ctrl.busy && !ctrl.resp)
    `PPT_ASSERT_NEXT(a_done_single, done, !done)

endmodule

FILE: bench/paired_page_tlb_translator_tb.sv
`timescale 1ns / 1ps

module paired_page_tlb_translator_tb;

    localparam int ENTRIES      = 32;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int AIM_DEPTH    = 40;

    typedef struct packed {
        ppt_pkg::op_t op;
        logic [5:0]  idx;
        logic [31:0] mask;
        logic [31:0] va;
        logic [31:0] pe;
        logic [31:0] po;
        logic [7:0]  gap;
        logic        drain;
    } tlb_cmd_t;

    typedef struct packed {
        logic [31:0] pa;
        logic        hit;
        logic        direct;
    } tlb_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = ppt_pkg::OP_MAP;
    logic [5:0]  entry_index = '0;
    logic [31:0] pair_mask = '0;
    logic [31:0] address = '0;
    logic [31:0] phys_even = '0;
    logic [31:0] phys_odd = '0;
    logic        done;
    logic [31:0] physical_address;
    logic        tlb_hit;
    logic        direct_mapped;

    // shadow of the translation table
    logic [31:0] tbl_vbase [ENTRIES];
    logic [31:0] tbl_size [ENTRIES];
    logic [31:0] tbl_even [ENTRIES];
    logic [31:0] tbl_odd [ENTRIES];
    logic        tbl_valid [ENTRIES];

    tlb_cmd_t    cmd_q [$];
    tlb_result_t xlate_expect_q [$];
    tlb_cmd_t    cur_cmd;
    logic        hold;
    int unsigned gap_count;
    int unsigned issued_count = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned total_items;

    // generator state
    logic        quiet_stretch = 1'b0;
    logic        drain_next = 1'b0;
    logic [31:0] aim_base [$];
    longint unsigned aim_span [$];

    paired_page_tlb_translator #(
        .ENTRY_COUNT(ENTRIES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .entry_index(entry_index),
        .pair_mask(pair_mask),
        .address(address),
        .phys_even(phys_even),
        .phys_odd(phys_odd),
        .done(done),
        .physical_address(physical_address),
        .tlb_hit(tlb_hit),
        .direct_mapped(direct_mapped)
    );

    always #2 clk = ~clk;

    initial
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            tbl_vbase[k] = '0;
            tbl_size[k]  = '0;
            tbl_even[k]  = '0;
            tbl_odd[k]   = '0;
            tbl_valid[k] = 1'b0;
        end
    end

    function automatic tlb_result_t apply_cmd(tlb_cmd_t c);
        tlb_result_t r;
        logic [31:0] sum;
        logic [31:0] sz;
        logic [31:0] dbl;
        logic [31:0] off;
        logic [31:0] t;
        logic        found;
        r = '0;
        case (c.op)
            ppt_pkg::OP_MAP:
            begin
                if (c.idx < ENTRIES)
                begin
                    sum = (c.mask | ppt_pkg::SIZE_FLOOR_MASK) + 32'd1;
                    sz = sum >> 1;
                    tbl_size[c.idx]  = sz;
                    tbl_vbase[c.idx] = c.va;
                    tbl_even[c.idx]  = c.pe;
                    tbl_odd[c.idx]   = c.po;
                    tbl_valid[c.idx] = (sz != 32'd0);
                end
            end
            ppt_pkg::OP_UNMAP:
            begin
                for (int k = 0; k < ENTRIES; k++)
                begin
                    dbl = tbl_size[k] << 1;
                    sum = tbl_vbase[k] + dbl;
                    if (tbl_valid[k] && c.va >= tbl_vbase[k] && c.va < sum)
                        tbl_valid[k] = 1'b0;
                end
            end
            ppt_pkg::OP_UNMAP_ALL:
            begin
                for (int k = 0; k < ENTRIES; k++)
                    tbl_valid[k] = 1'b0;
            end
            default:
            begin
                if (c.va >= ppt_pkg::WINDOW_LOW && c.va < ppt_pkg::WINDOW_HIGH)
                begin
                    r.direct = 1'b1;
                    r.pa = c.va & ppt_pkg::WINDOW_OFFSET_MASK;
                end
                else
                begin
                    t = '0;
                    found = 1'b0;
                    for (int k = 0; k < ENTRIES; k++)
                    begin
                        if (!found && tbl_valid[k])
                        begin
                            sz = tbl_size[k];
                            dbl = sz << 1;
                            off = c.va - tbl_vbase[k];
                            if (off < sz)
                            begin
                                t = tbl_even[k] + off;
                                found = 1'b1;
                            end
                            else if (off < dbl)
                            begin
                                t = tbl_odd[k] + (off - sz);
                                found = 1'b1;
                            end
                        end
                    end
                    r.hit = found;
                    r.pa = (t != 32'd0) ? t : c.va;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_gap();
        int unsigned roll;
        if (quiet_stretch)
            return 8'd0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 8'd0;
        if (roll < 92)
            return 8'($urandom_range(1, 4));
        return 8'($urandom_range(10, 60));
    endfunction

    function automatic void add_cmd(ppt_pkg::op_t op, logic [5:0] idx, logic [31:0] mask,
                                    logic [31:0] va, logic [31:0] pe, logic [31:0] po);
        tlb_cmd_t c;
        c.op    = op;
        c.idx   = idx;
        c.mask  = mask;
        c.va    = va;
        c.pe    = pe;
        c.po    = po;
        c.gap   = pick_gap();
        c.drain = drain_next;
        drain_next = 1'b0;
        cmd_q.push_back(c);
    endfunction

    function automatic logic [31:0] pick_mask();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return 32'd0;
        if (roll < 7)
            return (32'd1 << $urandom_range(13, 26)) - 32'd1;
        if (roll < 9)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_base();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return $urandom & 32'h7FFF_F000;
        if (roll < 8)
            return $urandom;
        if (roll < 9)
            return ppt_pkg::WINDOW_LOW | ($urandom & 32'h3FFF_FFFF);
        return ppt_pkg::WINDOW_HIGH | $urandom;
    endfunction

    function automatic logic [31:0] aimed_address();
        int unsigned k;
        longint unsigned off;
        if (aim_base.size() == 0 || $urandom_range(0, 9) < 3)
            return pick_base() | ($urandom & 32'h0000_0FFF);
        k = $urandom_range(0, aim_base.size() - 1);
        off = longint'($urandom) % (aim_span[k] + 64);
        return aim_base[k] + off[31:0];
    endfunction

    initial
    begin
        int unsigned roll;
        tlb_cmd_t c;

        // reset-state lookups and the edges of the direct window
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0000_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'hBFFF_FFFF, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'hC000_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
        // smallest page pair, both halves and just past the end
        add_cmd(ppt_pkg::OP_MAP, 6'd0, 32'd0, 32'h0040_0000, 32'h1000_0000, 32'h2000_0000);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0040_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0040_0FFF, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0040_1000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0040_2000, 32'd0, 32'd0);
        // slots past the table are dropped
        add_cmd(ppt_pkg::OP_MAP, 6'd63, 32'd0, 32'h0050_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(ppt_pkg::OP_MAP, 6'd32, 32'd0, 32'h0050_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0050_0000, 32'd0, 32'd0);
        // all-ones mask wraps the size to zero
        add_cmd(ppt_pkg::OP_MAP, 6'd31, 32'hFFFF_FFFF, 32'h0060_0000,
                32'h0100_0000, 32'h0200_0000);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0060_0000, 32'd0, 32'd0);
        // overlap with slot 0, upper page maps to zero
        add_cmd(ppt_pkg::OP_MAP, 6'd5, 32'h001F_E000, 32'h0040_0000,
                32'h3000_0000, 32'h0000_0000);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0048_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0050_0000, 32'd0, 32'd0);
        // huge pair whose range wraps past the top
        add_cmd(ppt_pkg::OP_MAP, 6'd1, 32'hFFFF_0000, 32'hF000_0000,
                32'hFFFF_FFFF, 32'h1234_5678);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h1000_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'hC000_0000, 32'd0, 32'd0);
        // direct window wins over a table entry
        add_cmd(ppt_pkg::OP_MAP, 6'd2, 32'd0, 32'h8000_1000, 32'h0BAD_0000, 32'h0BAD_1000);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h8000_1000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_UNMAP, 6'd0, 32'd0, 32'hF000_0000, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_UNMAP, 6'd0, 32'd0, 32'h0040_0800, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h0040_0000, 32'd0, 32'd0);
        drain_next = 1'b1;
        add_cmd(ppt_pkg::OP_UNMAP_ALL, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_cmd(ppt_pkg::OP_TRANSLATE, 6'd0, 32'd0, 32'h1000_0000, 32'd0, 32'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                quiet_stretch = ($urandom_range(0, 4) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain_next = 1'b1;
            c.idx  = 6'($urandom);
            c.mask = $urandom;
            c.va   = $urandom;
            c.pe   = $urandom;
            c.po   = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 28)
            begin
                c.op = ppt_pkg::OP_MAP;
                if ($urandom_range(0, 11) == 0)
                    c.idx = 6'($urandom_range(32, 63));
                else
                    c.idx = 6'($urandom_range(0, 31));
                c.mask = pick_mask();
                c.va = pick_base();
                if (c.idx < ENTRIES && c.mask != 32'hFFFF_FFFF)
                begin
                    aim_base.push_back(c.va);
                    aim_span.push_back(longint'((c.mask | ppt_pkg::SIZE_FLOOR_MASK)) + 1);
                    if (aim_base.size() > AIM_DEPTH)
                    begin
                        void'(aim_base.pop_front());
                        void'(aim_span.pop_front());
                    end
                end
            end
            else if (roll < 38)
            begin
                c.op = ppt_pkg::OP_UNMAP;
                c.va = aimed_address();
            end
            else if (roll < 41)
            begin
                c.op = ppt_pkg::OP_UNMAP_ALL;
                aim_base.delete();
                aim_span.delete();
            end
            else
            begin
                c.op = ppt_pkg::OP_TRANSLATE;
                c.va = aimed_address();
            end
            add_cmd(c.op, c.idx, c.mask, c.va, c.pe, c.po);
        end
        total_items = cmd_q.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < total_items)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            operation   <= ppt_pkg::OP_MAP;
            entry_index <= '0;
            pair_mask   <= '0;
            address     <= '0;
            phys_even   <= '0;
            phys_odd    <= '0;
            gap_count = 0;
        end
        else
        begin
            hold = start;
            if (start && !busy)
            begin
                xlate_expect_q.push_back(apply_cmd(cur_cmd));
                issued_count++;
                hold = 1'b0;
            end
            if (!hold && cmd_q.size() != 0)
            begin
                // a draining beat waits for every outstanding result
                if (!(cmd_q[0].drain && issued_count != results_seen))
                begin
                    if (gap_count < cmd_q[0].gap)
                        gap_count++;
                    else
                    begin
                        cur_cmd = cmd_q.pop_front();
                        gap_count = 0;
                        hold = 1'b1;
                        operation   <= cur_cmd.op;
                        entry_index <= cur_cmd.idx;
                        pair_mask   <= cur_cmd.mask;
                        address     <= cur_cmd.va;
                        phys_even   <= cur_cmd.pe;
                        phys_odd    <= cur_cmd.po;
                    end
                end
            end
            start <= hold;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        tlb_result_t want;
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (xlate_expect_q.size() == 0)
            begin
                $error("result beat with no command outstanding");
                mismatch_count++;
            end
            else
            begin
                want = xlate_expect_q.pop_front();
                if (physical_address !== want.pa)
                begin
                    $error("physical_address: expected %h, got %h", want.pa, physical_address);
                    mismatch_count++;
                end
                if (tlb_hit !== want.hit)
                begin
                    $error("tlb_hit: expected %b, got %b", want.hit, tlb_hit);
                    mismatch_count++;
                end
                if (direct_mapped !== want.direct)
                begin
                    $error("direct_mapped: expected %b, got %b", want.direct, direct_mapped);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_addsub.sv
rtl/ppt_entry_mem.sv
rtl/ppt_seq.sv
rtl/paired_page_tlb_translator.sv
bench/paired_page_tlb_translator_tb.sv
